### rtl/tprq_pkg.sv
`default_nettype none

package tprq_pkg;

    // default number of floors, also the depth of each queue
    localparam int unsigned FLOORS_DEF = 64;

    localparam int unsigned FLOOR_W = 6;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 8;

    // command codes carried in the input tuser
    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // priority codes
    localparam logic PRIO_LOW  = 1'b0;
    localparam logic PRIO_HIGH = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_ACCEPTED = 2'd0,
        KIND_REFUSED  = 2'd1,
        KIND_STOP     = 2'd2,
        KIND_NOTHING  = 2'd3
    } t_kind;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_DRAIN = 1'b1
    } t_state;

    // control for one queue chain
    typedef struct packed {
        logic load;   // write the tail cell selected by the count
        logic shift;  // every cell takes its upstream neighbor, head leaves
    } t_chain_ctl;

endpackage

`default_nettype wire

### rtl/tprq_cell.sv
`default_nettype none

module tprq_cell
    import tprq_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_load,
    input  wire logic               i_shift,
    input  wire logic [FLOOR_W-1:0] i_wr_floor,
    input  wire logic [FLOOR_W-1:0] i_next_floor,
    output logic      [FLOOR_W-1:0] o_floor
);

    logic [FLOOR_W-1:0] r_floor;

    // shift wins; loads never coincide with shifts
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_floor <= i_next_floor;
        end else if (i_load) begin
            r_floor <= i_wr_floor;
        end
    end

    assign o_floor = r_floor;

endmodule

`default_nettype wire

### rtl/tprq_chain.sv
`default_nettype none

module tprq_chain
    import tprq_pkg::*;
#(
    parameter int unsigned DEPTH = FLOORS_DEF,
    localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic               i_clk,
    input  wire t_chain_ctl         i_ctl,
    input  wire logic [CNT_W-1:0]   i_count,
    input  wire logic [FLOOR_W-1:0] i_wr_floor,
    output logic      [FLOOR_W-1:0] o_head
);

    logic [FLOOR_W-1:0] w_floor [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [FLOOR_W-1:0] w_next;
        logic               w_load;

        if (g == DEPTH - 1) begin : g_tail
            assign w_next = '0;
        end else begin : g_mid
            assign w_next = w_floor[g+1];
        end

        // the cell at the fill level takes a new entry
        assign w_load = i_ctl.load && (i_count == CNT_W'(g));

        tprq_cell u_cell (
            .i_clk        (i_clk),
            .i_load       (w_load),
            .i_shift      (i_ctl.shift),
            .i_wr_floor   (i_wr_floor),
            .i_next_floor (w_next),
            .o_floor      (w_floor[g])
        );
    end

    assign o_head = w_floor[0];

endmodule

`default_nettype wire

### rtl/two_level_priority_request_queue_top.sv
`default_nettype none

// channel   dir  tdata                                   tuser         tlast
// s_axis    in   [0] priority_req, [6:1] floor, [7] 0    [0] command   -
// m_axis    out  [5:0] stop_floor, [6] served_priority,  [1:0] kind    last
//                [7] 0
//
// an add: the pending bitmap decides accept or refuse and the result goes straight
// into the output register; so does the nothing result of an empty drain
// a drain of queued floors holds the input after its accept cycle and pops the head
// cell of a chain, one per cycle while the output register is free or being taken
// reset clears the counts, the bitmap and the state; queue cells are not reset
// a stalled m_axis holds the result and stops the drain; s_axis is taken again
// once the drain is over and the output register is free or being taken

module two_level_priority_request_queue_top
    import tprq_pkg::*;
#(
    parameter int unsigned FLOORS = FLOORS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,

    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // [0] priority_req, [6:1] floor, [7] zero fill
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // [0] command
    input  wire logic                   s_axis_tuser,

    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // [5:0] stop_floor, [6] served_priority, [7] zero fill
    output logic      [OUT_TDATA_W-1:0] m_axis_tdata,
    // [1:0] kind
    output logic      [KIND_W-1:0]      m_axis_tuser,
    output logic                        m_axis_tlast
);

    localparam int unsigned CNT_W = $clog2(FLOORS + 1);
    localparam int unsigned IDX_W = $clog2(FLOORS);

    // input fields
    logic               w_cmd;
    logic               w_prio;
    logic [FLOOR_W-1:0] w_floor;

    assign w_cmd   = s_axis_tuser;
    assign w_prio  = s_axis_tdata[0];
    assign w_floor = s_axis_tdata[FLOOR_W:1];

    // state
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_hcnt, n_hcnt;
    logic [CNT_W-1:0]   r_lcnt, n_lcnt;
    logic [FLOORS-1:0]  r_pending, n_pending;

    // output register
    logic               r_ovalid, n_ovalid;
    t_kind              r_okind, n_okind;
    logic [FLOOR_W-1:0] r_ofloor, n_ofloor;
    logic               r_oprio, n_oprio;
    logic               r_olast, n_olast;

    // chains
    t_chain_ctl         w_hctl, w_lctl;
    logic [FLOOR_W-1:0] w_hhead, w_lhead;

    // handshake helpers
    logic               w_out_free;
    logic               w_in_acc;
    logic               w_in_range;
    logic               w_dup;
    logic               w_add_ok;
    logic               w_empty;
    logic               w_pop_last;

    assign w_out_free = !r_ovalid || m_axis_tready;
    assign w_in_acc   = s_axis_tvalid && s_axis_tready;
    assign w_in_range = {1'b0, w_floor} < (FLOOR_W + 1)'(FLOORS);
    assign w_dup      = r_pending[w_floor[IDX_W-1:0]];
    assign w_add_ok   = w_in_range && !w_dup;
    assign w_empty    = (r_hcnt == '0) && (r_lcnt == '0);
    // the entry leaving now is the final one of the drain
    assign w_pop_last = ((r_hcnt == CNT_W'(1)) && (r_lcnt == '0))
                     || ((r_hcnt == '0) && (r_lcnt == CNT_W'(1)));

    tprq_chain #(
        .DEPTH (FLOORS)
    ) u_high (
        .i_clk      (i_clk),
        .i_ctl      (w_hctl),
        .i_count    (r_hcnt),
        .i_wr_floor (w_floor),
        .o_head     (w_hhead)
    );

    tprq_chain #(
        .DEPTH (FLOORS)
    ) u_low (
        .i_clk      (i_clk),
        .i_ctl      (w_lctl),
        .i_count    (r_lcnt),
        .i_wr_floor (w_floor),
        .o_head     (w_lhead)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc && (w_cmd == CMD_DRAIN) && !w_empty) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (w_out_free && w_pop_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs and datapath control
    always_comb begin
        s_axis_tready = 1'b0;
        w_hctl        = '0;
        w_lctl        = '0;
        n_hcnt        = r_hcnt;
        n_lcnt        = r_lcnt;
        n_pending     = r_pending;
        n_ovalid      = r_ovalid && !m_axis_tready;
        n_okind       = r_okind;
        n_ofloor      = r_ofloor;
        n_oprio       = r_oprio;
        n_olast       = r_olast;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = w_out_free;
                if (w_in_acc) begin
                    n_ovalid = 1'b1;
                    n_olast  = 1'b1;
                    if (w_cmd == CMD_ADD) begin
                        n_ofloor = w_floor;
                        n_oprio  = w_prio;
                        if (w_add_ok) begin
                            n_okind = KIND_ACCEPTED;
                            n_pending[w_floor[IDX_W-1:0]] = 1'b1;
                            if (w_prio == PRIO_HIGH) begin
                                w_hctl.load = 1'b1;
                                n_hcnt      = r_hcnt + CNT_W'(1);
                            end else begin
                                w_lctl.load = 1'b1;
                                n_lcnt      = r_lcnt + CNT_W'(1);
                            end
                        end else begin
                            n_okind = KIND_REFUSED;
                        end
                    end else begin
                        // drain start: bitmap empties now; stops follow if queued
                        n_pending = '0;
                        if (w_empty) begin
                            n_okind  = KIND_NOTHING;
                            n_ofloor = '0;
                            n_oprio  = PRIO_LOW;
                        end else begin
                            n_ovalid = r_ovalid && !m_axis_tready;
                        end
                    end
                end
            end
            ST_DRAIN: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_okind  = KIND_STOP;
                    n_olast  = w_pop_last;
                    if (r_hcnt != '0) begin
                        n_ofloor     = w_hhead;
                        n_oprio      = PRIO_HIGH;
                        w_hctl.shift = 1'b1;
                        n_hcnt       = r_hcnt - CNT_W'(1);
                    end else begin
                        n_ofloor     = w_lhead;
                        n_oprio      = PRIO_LOW;
                        w_lctl.shift = 1'b1;
                        n_lcnt       = r_lcnt - CNT_W'(1);
                    end
                end
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_hcnt    <= '0;
            r_lcnt    <= '0;
            r_pending <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_hcnt    <= n_hcnt;
            r_lcnt    <= n_lcnt;
            r_pending <= n_pending;
            r_ovalid  <= n_ovalid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_okind  <= n_okind;
        r_ofloor <= n_ofloor;
        r_oprio  <= n_oprio;
        r_olast  <= n_olast;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {1'b0, r_oprio, r_ofloor};
    assign m_axis_tuser  = r_okind;
    assign m_axis_tlast  = r_olast;

endmodule

`default_nettype wire

### tb/floor_queue_checker.sv
`timescale 1ns / 100ps

module floor_queue_checker
    import tprq_pkg::*;
#(
    parameter int unsigned FLOORS = FLOORS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,

    input  wire logic                   i_in_valid,
    input  wire logic                   i_in_ready,
    // [0] priority_req, [6:1] floor, [7] zero fill
    input  wire logic [IN_TDATA_W-1:0]  i_in_data,
    // [0] command
    input  wire logic                   i_in_user,

    input  wire logic                   i_out_valid,
    input  wire logic                   i_out_ready,
    // [5:0] stop_floor, [6] served_priority, [7] zero fill
    input  wire logic [OUT_TDATA_W-1:0] i_out_data,
    // [1:0] kind
    input  wire logic [KIND_W-1:0]      i_out_user,
    input  wire logic                   i_out_last,

    output int                          o_fail_count,
    output int                          o_due_count,
    output int                          o_result_count,
    output int                          o_longest_drain
);

    typedef struct {
        t_kind              kind;
        logic [FLOOR_W-1:0] stop_floor;
        logic               served_priority;
        logic               last;
    } t_floor_result;

    t_floor_result      due_results[$];
    logic [FLOOR_W-1:0] high_floors[$];
    logic [FLOOR_W-1:0] low_floors[$];
    logic               floor_waiting[2**FLOOR_W];

    function automatic t_floor_result make_result(t_kind k, logic [FLOOR_W-1:0] fl,
                                                  logic prio, logic fin);
        t_floor_result r;
        r.kind            = k;
        r.stop_floor      = fl;
        r.served_priority = prio;
        r.last            = fin;
        return r;
    endfunction

    // append helpers for the expected results and both floor queues
    function automatic void append_due(t_floor_result r);
        due_results.insert(due_results.size(), r);
    endfunction

    function automatic void append_high(logic [FLOOR_W-1:0] fl);
        high_floors.insert(high_floors.size(), fl);
    endfunction

    function automatic void append_low(logic [FLOOR_W-1:0] fl);
        low_floors.insert(low_floors.size(), fl);
    endfunction

    // next state of both queues and the results one input transaction causes
    task automatic predict_floor_results(input logic cmd, input logic prio,
                                         input logic [FLOOR_W-1:0] fl);
        int n_high;
        int n_low;
        n_high = high_floors.size();
        n_low  = low_floors.size();
        if (cmd == CMD_ADD) begin
            if (fl >= FLOORS || floor_waiting[fl] ||
                (prio == PRIO_HIGH && n_high >= FLOORS) ||
                (prio == PRIO_LOW && n_low >= FLOORS)) begin
                append_due(make_result(KIND_REFUSED, fl, prio, 1'b1));
            end else begin
                if (prio == PRIO_HIGH) begin
                    append_high(fl);
                end else begin
                    append_low(fl);
                end
                floor_waiting[fl] = 1'b1;
                append_due(make_result(KIND_ACCEPTED, fl, prio, 1'b1));
            end
        end else if (n_high == 0 && n_low == 0) begin
            append_due(make_result(KIND_NOTHING, '0, PRIO_LOW, 1'b1));
        end else begin
            // high queue first in arrival order, then the low queue
            for (int i = 0; i < n_high; i++) begin
                append_due(make_result(KIND_STOP, high_floors[i], PRIO_HIGH,
                                       (i == n_high - 1) && (n_low == 0)));
            end
            for (int i = 0; i < n_low; i++) begin
                append_due(make_result(KIND_STOP, low_floors[i], PRIO_LOW,
                                       i == n_low - 1));
            end
            if (n_high + n_low > o_longest_drain) begin
                o_longest_drain = n_high + n_low;
            end
            high_floors.delete();
            low_floors.delete();
            foreach (floor_waiting[i]) floor_waiting[i] = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        t_floor_result want;
        if (!i_rst_n) begin
            due_results.delete();
            high_floors.delete();
            low_floors.delete();
            foreach (floor_waiting[i]) floor_waiting[i] = 1'b0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                predict_floor_results(i_in_user, i_in_data[0], i_in_data[6:1]);
            end
            if (i_out_valid && i_out_ready) begin
                o_result_count++;
                if (due_results.size() == 0) begin
                    $error("result transaction with none expected: kind %0d floor %0d",
                           i_out_user, i_out_data[5:0]);
                    o_fail_count++;
                end else begin
                    want = due_results.pop_front();
                    if (i_out_user !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, i_out_user);
                        o_fail_count++;
                    end
                    if (i_out_data[5:0] !== want.stop_floor) begin
                        $error("stop_floor: expected %0d, got %0d",
                               want.stop_floor, i_out_data[5:0]);
                        o_fail_count++;
                    end
                    if (i_out_data[6] !== want.served_priority) begin
                        $error("served_priority: expected %0d, got %0d",
                               want.served_priority, i_out_data[6]);
                        o_fail_count++;
                    end
                    if (i_out_last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, i_out_last);
                        o_fail_count++;
                    end
                end
            end
        end
        o_due_count = due_results.size();
    end

endmodule

### tb/tb_two_level_priority_request_queue_top.sv
`timescale 1ns / 100ps

module tb_two_level_priority_request_queue_top;

    import tprq_pkg::*;

    localparam int CYCLE_LIMIT    = 200000;  // far beyond the slowest correct run
    localparam int RX_HOLD_CYCLES = 150;     // long receiver hold-off
    localparam int RANDOM_ITEMS   = 300;
    localparam int END_WAIT       = 20;      // drain of 64 stops is done long before

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;

    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [0] priority_req, [6:1] floor, [7] 0
    logic                   s_axis_tuser = 1'b0; // [0] command

    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // [5:0] stop_floor, [6] served_priority
    logic [KIND_W-1:0]      m_axis_tuser;        // [1:0] kind
    logic                   m_axis_tlast;

    int fail_count;
    int due_count;
    int result_count;
    int longest_drain;

    int cycle_count = 0;
    int n_adds = 0;
    int n_drains = 0;

    // shared between the stimulus and the receiver
    bit quiet_phase = 1'b0;   // no idling on either side while set
    bit rx_hold_req = 1'b0;   // asks the receiver for a long hold-off
    int rx_hold_left = 0;

    two_level_priority_request_queue_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    floor_queue_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (s_axis_tvalid),
        .i_in_ready      (s_axis_tready),
        .i_in_data       (s_axis_tdata),
        .i_in_user       (s_axis_tuser),
        .i_out_valid     (m_axis_tvalid),
        .i_out_ready     (m_axis_tready),
        .i_out_data      (m_axis_tdata),
        .i_out_user      (m_axis_tuser),
        .i_out_last      (m_axis_tlast),
        .o_fail_count    (fail_count),
        .o_due_count     (due_count),
        .o_result_count  (result_count),
        .o_longest_drain (longest_drain)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog on the whole run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due", cycle_count, due_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver: random stalls, a calm stretch, and one long hold-off on request
    always @(posedge i_clk) begin
        if (rx_hold_req) begin
            rx_hold_req = 1'b0;
            rx_hold_left = RX_HOLD_CYCLES;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_axis_tready <= 1'b0;
        end else if (quiet_phase) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= 30);
        end
    end

    // one input transaction, with a random idle gap ahead of it
    // valid stays high from one transaction to the next unless a gap is taken
    task automatic offer_item(input logic cmd, input logic prio,
                              input logic [FLOOR_W-1:0] fl);
        int gap;
        if (!quiet_phase && $urandom_range(99) < 30) begin
            gap = $urandom_range(1, 4);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, fl, prio};
        s_axis_tuser  <= cmd;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (cmd == CMD_DRAIN) begin
            n_drains++;
        end else begin
            n_adds++;
        end
    endtask

    // sender pauses until every predicted result has come out
    task automatic pause_until_empty();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (due_count != 0) @(posedge i_clk);
    endtask

    // a run of adds, mostly ended by a drain; a narrow window makes duplicates likely
    task automatic add_burst();
        int n;
        int lo;
        bit narrow;
        logic [FLOOR_W-1:0] fl;
        n = $urandom_range(1, 20);
        narrow = $urandom_range(0, 1);
        lo = $urandom_range(0, 56);
        for (int i = 0; i < n; i++) begin
            fl = narrow ? FLOOR_W'(lo + $urandom_range(0, 7)) : FLOOR_W'($urandom_range(0, 63));
            offer_item(CMD_ADD, logic'($urandom_range(0, 1)), fl);
        end
        // now and then leave the queues loaded across the next burst
        if ($urandom_range(99) < 85) begin
            offer_item(CMD_DRAIN, logic'($urandom_range(0, 1)),
                       FLOOR_W'($urandom_range(0, 63)));
        end
    endtask

    // every floor once in shuffled order, then the largest drain there is
    task automatic fill_every_floor();
        logic [FLOOR_W-1:0] order[64];
        logic [FLOOR_W-1:0] tmp;
        int j;
        foreach (order[i]) order[i] = FLOOR_W'(i);
        for (int i = 63; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        foreach (order[i]) offer_item(CMD_ADD, logic'($urandom_range(0, 1)), order[i]);
        offer_item(CMD_DRAIN, PRIO_LOW, '0);
    endtask

    initial begin
        int random_start;
        int sent;
        bit did_hold;
        bit did_fill;

        did_hold = 1'b0;
        did_fill = 1'b0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty drain, floor extremes, duplicates across and within
        // queues, high-before-low order, last on each queue, reuse after drain
        offer_item(CMD_DRAIN, PRIO_HIGH, 6'd63);
        offer_item(CMD_ADD, PRIO_LOW, 6'd0);
        offer_item(CMD_ADD, PRIO_HIGH, 6'd63);
        offer_item(CMD_ADD, PRIO_HIGH, 6'd0);
        offer_item(CMD_ADD, PRIO_LOW, 6'd63);
        offer_item(CMD_ADD, PRIO_LOW, 6'd0);
        offer_item(CMD_ADD, PRIO_HIGH, 6'd21);
        offer_item(CMD_ADD, PRIO_LOW, 6'd42);
        offer_item(CMD_DRAIN, PRIO_LOW, 6'd0);
        offer_item(CMD_DRAIN, PRIO_LOW, 6'd0);
        offer_item(CMD_ADD, PRIO_HIGH, 6'd0);
        offer_item(CMD_ADD, PRIO_HIGH, 6'd5);
        offer_item(CMD_DRAIN, PRIO_HIGH, 6'd42);
        offer_item(CMD_ADD, PRIO_LOW, 6'd7);
        offer_item(CMD_ADD, PRIO_LOW, 6'd56);
        offer_item(CMD_ADD, PRIO_HIGH, 6'd56);
        offer_item(CMD_DRAIN, PRIO_LOW, 6'd21);
        pause_until_empty();

        // random part
        random_start = n_adds + n_drains;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if (!did_hold && sent >= 60) begin
                // receiver stops while adds keep coming, so the input stalls
                did_hold = 1'b1;
                rx_hold_req = 1'b1;
                for (int i = 0; i < 16; i++) begin
                    offer_item(CMD_ADD, logic'($urandom_range(0, 1)),
                               FLOOR_W'($urandom_range(0, 63)));
                end
                offer_item(CMD_DRAIN, PRIO_LOW, '0);
                pause_until_empty();
            end else if (!did_fill && sent >= 120) begin
                did_fill = 1'b1;
                fill_every_floor();
            end else if ($urandom_range(99) < 75) begin
                add_burst();
            end else begin
                // loose noise: any command, any fields
                offer_item(logic'($urandom_range(0, 2) == 0), logic'($urandom_range(0, 1)),
                           FLOOR_W'($urandom_range(0, 63)));
            end
            sent = n_adds + n_drains - random_start;
            // a stretch with no idling on either side
            quiet_phase = (sent >= 180 && sent < 240);
        end
        quiet_phase = 1'b0;

        // flush anything still queued, then let the block settle
        offer_item(CMD_DRAIN, PRIO_LOW, '0);
        pause_until_empty();
        repeat (END_WAIT) @(posedge i_clk);

        $display("covered %0d adds and %0d drains, %0d result transactions checked",
                 n_adds, n_drains, result_count);
        $display("longest drain %0d stops, with duplicates, empty drains and a stalled output",
                 longest_drain);
        if (fail_count == 0 && due_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
